// ----- rtl/priority_message_queue_scheduler_macros.svh -----
// Assertion macros used by the scheduler control module.
// The asserting module must have aclk and aresetn in scope.
`ifndef PRIORITY_MESSAGE_QUEUE_SCHEDULER_MACROS_SVH
`define PRIORITY_MESSAGE_QUEUE_SCHEDULER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PMQS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PMQS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pmqs_pkg.sv -----
package pmqs_pkg;

    localparam int LINK_W    = 6;
    localparam int TASK_W    = 4;
    localparam int SRC_W     = 5;
    localparam int SIG_W     = 8;
    localparam int LVL_W     = 4;
    localparam int LQ_W      = 3;
    localparam int SLOT_W    = 5;
    localparam int CNT_OUT_W = 6;
    localparam int TCNT_W    = 5;
    localparam int TABLE_W   = 48;
    localparam int CFG_IDX_W = 1;

    localparam logic [LINK_W-1:0]    NIL       = 6'd63;
    localparam logic [SRC_W-1:0]     IDLE_TASK = 5'd16;
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_TABLE = 1'd1;

    typedef enum logic [1:0] {
        OP_POST     = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_DISPATCH = 2'd2,
        OP_LEAVE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_BAD_TASK = 2'd1,
        STS_EMPTY    = 2'd2
    } status_t;

    typedef struct packed {
        logic [TASK_W-1:0] dest;
        logic [SRC_W-1:0]  src;
        logic [SIG_W-1:0]  sig;
    } slot_data_t;

    typedef struct packed {
        logic              rd_en;
        logic [LINK_W-1:0] rd_addr;
        logic              link_we;
        logic              data_we;
        logic [LINK_W-1:0] wr_addr;
        logic [LINK_W-1:0] link_wdata;
        slot_data_t        data_wdata;
    } mem_req_t;

    typedef struct packed {
        status_t              status;
        logic [SLOT_W-1:0]    slot;
        logic [TASK_W-1:0]    dest;
        logic [SRC_W-1:0]     src;
        logic [SIG_W-1:0]     sig;
        logic [LVL_W-1:0]     level;
        logic                 slot_valid;
        logic [CNT_OUT_W-1:0] count;
        logic                 last;
    } result_t;

endpackage

// ----- rtl/pmqs_slot_store.sv -----
module pmqs_slot_store #(
    parameter int MSG_SLOTS = 32
) (
    input  logic                            aclk,
    input  pmqs_pkg::mem_req_t              req,
    output logic [pmqs_pkg::LINK_W-1:0]     rd_link,
    output pmqs_pkg::slot_data_t            rd_data
);

    localparam int ADDR_W = (MSG_SLOTS > 1) ? $clog2(MSG_SLOTS) : 1;

    logic [pmqs_pkg::LINK_W-1:0] link_mem [MSG_SLOTS];
    pmqs_pkg::slot_data_t        data_mem [MSG_SLOTS];
    logic [pmqs_pkg::LINK_W-1:0] rd_link_reg;
    pmqs_pkg::slot_data_t        rd_data_reg;

    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;

    assign waddr = req.wr_addr[ADDR_W-1:0];
    assign raddr = req.rd_addr[ADDR_W-1:0];

    // Write-first: a read of the entry written in the same cycle sees the new value.
    always_ff @(posedge aclk) begin
        if (req.link_we) begin
            link_mem[waddr] <= req.link_wdata;
        end
        if (req.data_we) begin
            data_mem[waddr] <= req.data_wdata;
        end
        if (req.rd_en) begin
            rd_link_reg <= (req.link_we && waddr == raddr) ? req.link_wdata : link_mem[raddr];
            rd_data_reg <= (req.data_we && waddr == raddr) ? req.data_wdata : data_mem[raddr];
        end
    end

    assign rd_link = rd_link_reg;
    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/pmqs_out_reg.sv -----
module pmqs_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  pmqs_pkg::result_t   push_data,
    output logic                out_free,
    output logic                m_valid,
    input  logic                m_ready,
    output pmqs_pkg::result_t   m_data
);

    logic              valid_reg;
    logic              valid_next;
    pmqs_pkg::result_t data_reg;

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (push) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (push) begin
            data_reg <= push_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ----- rtl/pmqs_ctrl.sv -----
`include "priority_message_queue_scheduler_macros.svh"

module pmqs_ctrl #(
    parameter int LEVELS    = 8,
    parameter int MSG_SLOTS = 32,
    parameter int MAX_TASKS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [pmqs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pmqs_pkg::TABLE_W-1:0]       cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         in_opcode,
    input  logic [pmqs_pkg::SLOT_W-1:0]        in_slot,
    input  logic [pmqs_pkg::TASK_W-1:0]        in_task,
    input  logic [pmqs_pkg::SIG_W-1:0]         in_signal,
    input  logic [pmqs_pkg::LVL_W-1:0]         in_thr,
    output pmqs_pkg::mem_req_t                 mem_req,
    input  logic [pmqs_pkg::LINK_W-1:0]        rd_link,
    input  pmqs_pkg::slot_data_t               rd_data,
    output logic                               res_push,
    output pmqs_pkg::result_t                  res,
    input  logic                               out_free
);

    localparam int CNT_W  = $clog2(MSG_SLOTS + 1);
    localparam int LINK_W = pmqs_pkg::LINK_W;
    localparam int LQ_W   = pmqs_pkg::LQ_W;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EXEC    = 6'b000010,
        S_POST2   = 6'b000100,
        S_WALK    = 6'b001000,
        S_REM_END = 6'b010000,
        S_DSP     = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    pmqs_pkg::op_t op_reg, op_next;
    logic [LINK_W-1:0] slot_reg, slot_next;
    logic [pmqs_pkg::TASK_W-1:0] task_reg, task_next;
    logic [pmqs_pkg::SIG_W-1:0] sig_reg, sig_next;
    logic [pmqs_pkg::LVL_W-1:0] thr_reg, thr_next;
    logic [LQ_W-1:0] q_reg, q_next;
    logic [LINK_W-1:0] head_reg [LEVELS];
    logic [LINK_W-1:0] head_next [LEVELS];
    logic [LINK_W-1:0] tail_reg [LEVELS];
    logic [LINK_W-1:0] tail_next [LEVELS];
    logic [LEVELS-1:0] ready_reg, ready_next;
    logic [pmqs_pkg::SRC_W-1:0] running_reg, running_next;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] prev_reg, prev_next;
    logic [CNT_W-1:0] steps_reg, steps_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic pend_valid_reg, pend_valid_next;
    logic [LINK_W-1:0] pend_slot_reg, pend_slot_next;
    logic [pmqs_pkg::TCNT_W-1:0] task_count_reg;
    logic [pmqs_pkg::TABLE_W-1:0] level_table_reg;

    logic task_ok;
    logic [LQ_W-1:0] q_dec;
    logic [2:0] tbl_entry;
    logic [pmqs_pkg::LVL_W-1:0] top_lvl;
    logic [LQ_W-1:0] top_q;

    function automatic logic [LINK_W-1:0] fix_link(input logic [LINK_W-1:0] v);
        return ({1'b0, v} < (LINK_W+1)'(MSG_SLOTS)) ? v : pmqs_pkg::NIL;
    endfunction

    // Slot number modulo MSG_SLOTS by restoring subtraction.
    function automatic logic [LINK_W-1:0] reduce_slot(input logic [pmqs_pkg::SLOT_W-1:0] v);
        logic [11:0] r;
        r = 12'(v);
        for (int k = 4; k >= 0; k--) begin
            if (r >= (12'(MSG_SLOTS) << k)) begin
                r = r - (12'(MSG_SLOTS) << k);
            end
        end
        return r[LINK_W-1:0];
    endfunction

    assign task_ok = ({1'b0, task_reg} < task_count_reg)
                  && ({1'b0, task_reg} < pmqs_pkg::TCNT_W'(MAX_TASKS));
    assign tbl_entry = level_table_reg[{2'b00, task_reg} * 6'd3 +: 3];
    assign q_dec = (32'(tbl_entry) >= LEVELS) ? LQ_W'(LEVELS - 1) : tbl_entry;

    always_comb begin
        top_lvl = '0;
        for (int b = 0; b < LEVELS; b++) begin
            if (ready_reg[b]) begin
                top_lvl = pmqs_pkg::LVL_W'(b + 1);
            end
        end
    end
    assign top_q = LQ_W'(top_lvl - 1'b1);

    always_comb begin
        logic [LINK_W-1:0] nxt;
        logic [LINK_W-1:0] hfix;
        logic [LINK_W-1:0] new_head;
        logic [CNT_W-1:0] steps_n;
        logic match;

        state_next = state_reg;
        op_next = op_reg;
        slot_next = slot_reg;
        task_next = task_reg;
        sig_next = sig_reg;
        thr_next = thr_reg;
        q_next = q_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        ready_next = ready_reg;
        running_next = running_reg;
        cur_next = cur_reg;
        prev_next = prev_reg;
        steps_next = steps_reg;
        cnt_next = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next = pend_slot_reg;
        mem_req = '0;
        res = '0;
        res.status = pmqs_pkg::STS_OK;
        res_push = 1'b0;
        in_ready = (state_reg == S_IDLE);
        nxt = fix_link(rd_link);
        hfix = pmqs_pkg::NIL;
        new_head = pmqs_pkg::NIL;
        steps_n = steps_reg + 1'b1;
        match = (rd_data.dest == task_reg) && (rd_data.sig == sig_reg);

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next = pmqs_pkg::op_t'(in_opcode);
                    slot_next = reduce_slot(in_slot);
                    task_next = in_task;
                    sig_next = in_signal;
                    thr_next = in_thr;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    res.last = 1'b1;
                    case (op_reg)
                        pmqs_pkg::OP_LEAVE: begin
                            running_next = pmqs_pkg::IDLE_TASK;
                            res_push = 1'b1;
                            state_next = S_IDLE;
                        end
                        pmqs_pkg::OP_POST: begin
                            if (!task_ok) begin
                                res.status = pmqs_pkg::STS_BAD_TASK;
                                res_push = 1'b1;
                                state_next = S_IDLE;
                            end else begin
                                q_next = q_dec;
                                mem_req.link_we = 1'b1;
                                mem_req.data_we = 1'b1;
                                mem_req.wr_addr = slot_reg;
                                mem_req.link_wdata = pmqs_pkg::NIL;
                                mem_req.data_wdata = '{dest: task_reg, src: running_reg,
                                                       sig: sig_reg};
                                if (tail_reg[q_dec] == pmqs_pkg::NIL) begin
                                    head_next[q_dec] = slot_reg;
                                    tail_next[q_dec] = slot_reg;
                                    ready_next[q_dec] = 1'b1;
                                    res_push = 1'b1;
                                    state_next = S_IDLE;
                                end else begin
                                    state_next = S_POST2;
                                end
                            end
                        end
                        pmqs_pkg::OP_REMOVE: begin
                            if (!task_ok) begin
                                res.status = pmqs_pkg::STS_BAD_TASK;
                                res_push = 1'b1;
                                state_next = S_IDLE;
                            end else begin
                                q_next = q_dec;
                                cnt_next = '0;
                                steps_next = '0;
                                pend_valid_next = 1'b0;
                                prev_next = pmqs_pkg::NIL;
                                hfix = fix_link(head_reg[q_dec]);
                                if (ready_reg[q_dec] && hfix != pmqs_pkg::NIL) begin
                                    mem_req.rd_en = 1'b1;
                                    mem_req.rd_addr = hfix;
                                    cur_next = hfix;
                                    state_next = S_WALK;
                                end else begin
                                    state_next = S_REM_END;
                                end
                            end
                        end
                        pmqs_pkg::OP_DISPATCH: begin
                            if (top_lvl == '0 || top_lvl <= thr_reg) begin
                                res.status = pmqs_pkg::STS_EMPTY;
                                res_push = 1'b1;
                                state_next = S_IDLE;
                            end else begin
                                q_next = top_q;
                                hfix = fix_link(head_reg[top_q]);
                                if (hfix == pmqs_pkg::NIL) begin
                                    ready_next[top_q] = 1'b0;
                                    res.status = pmqs_pkg::STS_EMPTY;
                                    res_push = 1'b1;
                                    state_next = S_IDLE;
                                end else begin
                                    mem_req.rd_en = 1'b1;
                                    mem_req.rd_addr = hfix;
                                    cur_next = hfix;
                                    state_next = S_DSP;
                                end
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_POST2: begin
                if (out_free) begin
                    mem_req.link_we = 1'b1;
                    mem_req.wr_addr = tail_reg[q_reg];
                    mem_req.link_wdata = slot_reg;
                    tail_next[q_reg] = slot_reg;
                    res.last = 1'b1;
                    res_push = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_WALK: begin
                // Each match is held until the next match or the end of the walk, so the final one can carry the count.
                if (!(match && pend_valid_reg && !out_free)) begin
                    steps_next = steps_n;
                    if (match) begin
                        if (pend_valid_reg) begin
                            res.slot = pend_slot_reg[pmqs_pkg::SLOT_W-1:0];
                            res.slot_valid = 1'b1;
                            res_push = 1'b1;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next = cur_reg;
                        cnt_next = cnt_reg + 1'b1;
                        if (prev_reg == pmqs_pkg::NIL) begin
                            head_next[q_reg] = nxt;
                            new_head = nxt;
                        end else begin
                            mem_req.link_we = 1'b1;
                            mem_req.wr_addr = prev_reg;
                            mem_req.link_wdata = nxt;
                            new_head = head_reg[q_reg];
                        end
                        if (nxt == pmqs_pkg::NIL) begin
                            tail_next[q_reg] = prev_reg;
                            if (new_head == pmqs_pkg::NIL) begin
                                ready_next[q_reg] = 1'b0;
                            end
                        end
                    end else begin
                        prev_next = cur_reg;
                    end
                    cur_next = nxt;
                    if (nxt != pmqs_pkg::NIL && steps_n < CNT_W'(MSG_SLOTS)) begin
                        mem_req.rd_en = 1'b1;
                        mem_req.rd_addr = nxt;
                    end else begin
                        state_next = S_REM_END;
                    end
                end
            end
            S_REM_END: begin
                if (out_free) begin
                    res.slot = pend_valid_reg ? pend_slot_reg[pmqs_pkg::SLOT_W-1:0] : '0;
                    res.slot_valid = pend_valid_reg;
                    res.count = cnt_reg[pmqs_pkg::CNT_OUT_W-1:0];
                    res.last = 1'b1;
                    res_push = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DSP: begin
                if (out_free) begin
                    head_next[q_reg] = nxt;
                    if (nxt == pmqs_pkg::NIL) begin
                        tail_next[q_reg] = pmqs_pkg::NIL;
                        ready_next[q_reg] = 1'b0;
                    end
                    running_next = {1'b0, rd_data.dest};
                    res.slot = cur_reg[pmqs_pkg::SLOT_W-1:0];
                    res.dest = rd_data.dest;
                    res.src = rd_data.src;
                    res.sig = rd_data.sig;
                    res.level = pmqs_pkg::LVL_W'(q_reg) + 1'b1;
                    res.slot_valid = 1'b1;
                    res.last = 1'b1;
                    res_push = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i] <= pmqs_pkg::NIL;
                tail_reg[i] <= pmqs_pkg::NIL;
            end
            ready_reg <= '0;
            running_reg <= '0;
            pend_valid_reg <= 1'b0;
            task_count_reg <= '0;
            level_table_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            ready_reg <= ready_next;
            running_reg <= running_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    pmqs_pkg::CFG_TASK_COUNT: begin
                        task_count_reg <= cfg_wdata[pmqs_pkg::TCNT_W-1:0];
                    end
                    pmqs_pkg::CFG_LEVEL_TABLE: begin
                        level_table_reg <= cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
        end
        op_reg <= op_next;
        slot_reg <= slot_next;
        task_reg <= task_next;
        sig_reg <= sig_next;
        thr_reg <= thr_next;
        q_reg <= q_next;
        cur_reg <= cur_next;
        prev_reg <= prev_next;
        steps_reg <= steps_next;
        cnt_reg <= cnt_next;
        pend_slot_reg <= pend_slot_next;
    end

    `PMQS_ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state_reg == S_EXEC, "accepted item did not start")
    `PMQS_ASSERT_IMPL(a_push_free, res_push, out_free, "result pushed into a full output register")
    `PMQS_ASSERT_IMPL(a_walk_bound, state_reg == S_WALK, steps_reg < CNT_W'(MSG_SLOTS), "queue walk overran")

endmodule

// ----- rtl/priority_message_queue_scheduler.sv -----
// Priority message queue scheduler: one linked FIFO of message slots per priority
// level, with the slot links and message data held in a memory with a registered
// read port. Post writes the slot and, when the level queue is not empty, then
// links it behind the old tail. Remove walks the task's level queue one slot per
// cycle through the memory read port, pausing while a held match waits for the
// output register, for at most MSG_SLOTS steps, and gives one item per freed slot,
// the last one carrying the count (a single item when none is freed). A result
// waits while the output register is still full. Only one item is worked on at a
// time; a finished item may wait in the output register while the next is taken.
module priority_message_queue_scheduler #(
    parameter int LEVELS    = 8,
    parameter int MSG_SLOTS = 32,
    parameter int MAX_TASKS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [pmqs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pmqs_pkg::TABLE_W-1:0]        cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_opcode,
    input  logic [4:0]                          s_msg_slot,
    input  logic [3:0]                          s_task_id,
    input  logic [7:0]                          s_signal,
    input  logic [3:0]                          s_level_threshold,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic [4:0]                          m_msg_slot_out,
    output logic [3:0]                          m_dest_task,
    output logic [4:0]                          m_source_task,
    output logic [7:0]                          m_signal_out,
    output logic [3:0]                          m_level_out,
    output logic                                m_slot_valid,
    output logic [5:0]                          m_removed_count,
    output logic                                m_last
);

    pmqs_pkg::mem_req_t          mem_req;
    logic [pmqs_pkg::LINK_W-1:0] rd_link;
    pmqs_pkg::slot_data_t        rd_data;
    logic                        res_push;
    pmqs_pkg::result_t           res;
    logic                        out_free;
    pmqs_pkg::result_t           m_data;

    pmqs_ctrl #(
        .LEVELS    (LEVELS),
        .MSG_SLOTS (MSG_SLOTS),
        .MAX_TASKS (MAX_TASKS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_opcode (s_opcode),
        .in_slot   (s_msg_slot),
        .in_task   (s_task_id),
        .in_signal (s_signal),
        .in_thr    (s_level_threshold),
        .mem_req   (mem_req),
        .rd_link   (rd_link),
        .rd_data   (rd_data),
        .res_push  (res_push),
        .res       (res),
        .out_free  (out_free)
    );

    pmqs_slot_store #(
        .MSG_SLOTS (MSG_SLOTS)
    ) u_store (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_link (rd_link),
        .rd_data (rd_data)
    );

    pmqs_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    assign m_status        = m_data.status;
    assign m_msg_slot_out  = m_data.slot;
    assign m_dest_task     = m_data.dest;
    assign m_source_task   = m_data.src;
    assign m_signal_out    = m_data.sig;
    assign m_level_out     = m_data.level;
    assign m_slot_valid    = m_data.slot_valid;
    assign m_removed_count = m_data.count;
    assign m_last          = m_data.last;

endmodule

// ----- sim/tb_priority_message_queue_scheduler.sv -----
module tb_priority_message_queue_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS  = 32;
    localparam int WDOG_LIMIT = 5000;

    typedef enum logic [1:0] {
        ROW_SEND,
        ROW_TYPED,
        ROW_CFG_COUNT,
        ROW_CFG_TABLE
    } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        pmqs_pkg::op_t      op;
        logic [4:0]         slot;
        logic [3:0]         tid;
        logic [7:0]         sig;
        logic [3:0]         thr;
        pmqs_pkg::status_t  sts;
        logic [47:0]        data;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [pmqs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [pmqs_pkg::TABLE_W-1:0]   cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = '0;
    logic [4:0]  s_msg_slot = '0;
    logic [3:0]  s_task_id = '0;
    logic [7:0]  s_signal = '0;
    logic [3:0]  s_level_threshold = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [4:0]  m_msg_slot_out;
    logic [3:0]  m_dest_task;
    logic [4:0]  m_source_task;
    logic [7:0]  m_signal_out;
    logic [3:0]  m_level_out;
    logic        m_slot_valid;
    logic [5:0]  m_removed_count;
    logic        m_last;

    // Typed expectation travels with the item it belongs to.
    logic              typed_item = 1'b0;
    pmqs_pkg::result_t typed_result = '0;

    priority_message_queue_scheduler i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_msg_slot(s_msg_slot), .s_task_id(s_task_id), .s_signal(s_signal),
        .s_level_threshold(s_level_threshold),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_msg_slot_out(m_msg_slot_out), .m_dest_task(m_dest_task),
        .m_source_task(m_source_task), .m_signal_out(m_signal_out),
        .m_level_out(m_level_out), .m_slot_valid(m_slot_valid),
        .m_removed_count(m_removed_count), .m_last(m_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Scheduler image kept by the testbench.
    logic [5:0]  link_tab [NUM_SLOTS];
    logic [3:0]  msg_dest [NUM_SLOTS];
    logic [4:0]  msg_src [NUM_SLOTS];
    logic [7:0]  msg_sig [NUM_SLOTS];
    logic [5:0]  lvl_head [8];
    logic [5:0]  lvl_tail [8];
    logic [7:0]  ready_lvls = '0;
    logic [4:0]  current_task = '0;
    logic [4:0]  reg_task_count = '0;
    logic [47:0] reg_level_table = '0;
    logic [31:0] slot_queued = '0;

    pmqs_pkg::result_t pending_results[$];

    int errors = 0;
    int items_taken = 0;
    int results_seen = 0;
    int slots_freed = 0;
    int msgs_dispatched = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    initial begin
        for (int i = 0; i < 8; i++) begin
            lvl_head[i] = pmqs_pkg::NIL;
            lvl_tail[i] = pmqs_pkg::NIL;
        end
    end

    function automatic bit task_registered(logic [3:0] t);
        return {1'b0, t} < reg_task_count;
    endfunction

    function automatic int queue_of(logic [3:0] t);
        return int'(reg_level_table[3*t +: 3]);
    endfunction

    function automatic int link_or_nil(logic [5:0] s);
        return (s < NUM_SLOTS) ? int'(s) : int'(pmqs_pkg::NIL);
    endfunction

    function automatic pmqs_pkg::result_t single_result(pmqs_pkg::status_t st);
        pmqs_pkg::result_t r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic predict_item(pmqs_pkg::op_t op, logic [4:0] slot, logic [3:0] tid,
                                logic [7:0] sig, logic [3:0] thr);
        pmqs_pkg::result_t r;
        pmqs_pkg::result_t held;
        bit      have_held;
        int      q, cur, prv, nx, steps, cnt, lvl;
        r = single_result(pmqs_pkg::STS_OK);
        have_held = 0;
        cnt = 0;
        case (op)
            pmqs_pkg::OP_POST: begin
                if (!task_registered(tid)) begin
                    r.status = pmqs_pkg::STS_BAD_TASK;
                end else begin
                    q = queue_of(tid);
                    link_tab[slot] = pmqs_pkg::NIL;
                    msg_dest[slot] = tid;
                    msg_src[slot] = current_task;
                    msg_sig[slot] = sig;
                    if (lvl_tail[q] == pmqs_pkg::NIL) begin
                        lvl_head[q] = {1'b0, slot};
                        lvl_tail[q] = {1'b0, slot};
                        ready_lvls[q] = 1'b1;
                    end else begin
                        link_tab[lvl_tail[q][4:0]] = {1'b0, slot};
                        lvl_tail[q] = {1'b0, slot};
                    end
                    slot_queued[slot] = 1'b1;
                end
                pending_results.push_back(r);
            end
            pmqs_pkg::OP_REMOVE: begin
                if (!task_registered(tid)) begin
                    r.status = pmqs_pkg::STS_BAD_TASK;
                    pending_results.push_back(r);
                end else begin
                    q = queue_of(tid);
                    if (ready_lvls[q]) begin
                        cur = link_or_nil(lvl_head[q]);
                        prv = pmqs_pkg::NIL;
                        steps = 0;
                        while (cur != pmqs_pkg::NIL && steps < NUM_SLOTS) begin
                            nx = link_or_nil(link_tab[cur]);
                            steps++;
                            if (msg_dest[cur] == tid && msg_sig[cur] == sig) begin
                                if (prv == pmqs_pkg::NIL) lvl_head[q] = nx[5:0];
                                else link_tab[prv] = nx[5:0];
                                if (nx == pmqs_pkg::NIL) begin
                                    lvl_tail[q] = prv[5:0];
                                    if (lvl_head[q] == pmqs_pkg::NIL) ready_lvls[q] = 1'b0;
                                end
                                if (have_held) pending_results.push_back(held);
                                held = '0;
                                held.slot = cur[4:0];
                                held.slot_valid = 1'b1;
                                have_held = 1;
                                slot_queued[cur] = 1'b0;
                                cnt++;
                            end else begin
                                prv = cur;
                            end
                            cur = nx;
                        end
                    end
                    if (have_held) begin
                        held.count = cnt[5:0];
                        held.last = 1'b1;
                        pending_results.push_back(held);
                        slots_freed += cnt;
                    end else begin
                        pending_results.push_back(r);
                    end
                end
            end
            pmqs_pkg::OP_DISPATCH: begin
                lvl = 0;
                for (int b = 0; b < 8; b++)
                    if (ready_lvls[b]) lvl = b + 1;
                if (lvl == 0 || lvl <= int'(thr)) begin
                    r.status = pmqs_pkg::STS_EMPTY;
                end else begin
                    q = lvl - 1;
                    cur = link_or_nil(lvl_head[q]);
                    if (cur == pmqs_pkg::NIL) begin
                        ready_lvls[q] = 1'b0;
                        r.status = pmqs_pkg::STS_EMPTY;
                    end else begin
                        nx = link_or_nil(link_tab[cur]);
                        lvl_head[q] = nx[5:0];
                        if (nx == pmqs_pkg::NIL) begin
                            lvl_tail[q] = pmqs_pkg::NIL;
                            ready_lvls[q] = 1'b0;
                        end
                        current_task = {1'b0, msg_dest[cur]};
                        r.slot = cur[4:0];
                        r.dest = msg_dest[cur];
                        r.src = msg_src[cur];
                        r.sig = msg_sig[cur];
                        r.level = lvl[3:0];
                        r.slot_valid = 1'b1;
                        slot_queued[cur] = 1'b0;
                        msgs_dispatched++;
                    end
                end
                pending_results.push_back(r);
            end
            default: begin
                current_task = pmqs_pkg::IDLE_TASK;
                pending_results.push_back(r);
            end
        endcase
    endtask

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        int                n;
        pmqs_pkg::result_t e;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (s_valid && s_ready) begin
                items_taken++;
                n = pending_results.size();
                predict_item(pmqs_pkg::op_t'(s_opcode), s_msg_slot, s_task_id, s_signal,
                             s_level_threshold);
                if (typed_item) begin
                    while (pending_results.size() > n) void'(pending_results.pop_back());
                    pending_results.push_back(typed_result);
                end
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    $error("result item arrived with nothing expected");
                    errors++;
                end else begin
                    e = pending_results.pop_front();
                    check_field("status", e.status, m_status);
                    check_field("msg_slot_out", e.slot, m_msg_slot_out);
                    check_field("dest_task", e.dest, m_dest_task);
                    check_field("source_task", e.src, m_source_task);
                    check_field("signal_out", e.sig, m_signal_out);
                    check_field("level_out", e.level, m_level_out);
                    check_field("slot_valid", e.slot_valid, m_slot_valid);
                    check_field("removed_count", e.count, m_removed_count);
                    check_field("last", e.last, m_last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(pmqs_pkg::op_t op, logic [4:0] slot, logic [3:0] tid,
                             logic [7:0] sig, logic [3:0] thr, bit typed,
                             pmqs_pkg::status_t sts);
        s_valid <= 1'b1;
        s_opcode <= op;
        s_msg_slot <= slot;
        s_task_id <= tid;
        s_signal <= sig;
        s_level_threshold <= thr;
        typed_item <= typed;
        typed_result <= single_result(sts);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [pmqs_pkg::CFG_IDX_W-1:0] idx, logic [47:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == pmqs_pkg::CFG_TASK_COUNT) reg_task_count = value[4:0];
        else reg_level_table = value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_signal();
        if ($urandom_range(99) < 70) return 8'($urandom_range(3));
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [3:0] pick_task();
        if (reg_task_count != 0 && $urandom_range(99) < 90)
            return 4'($urandom_range(reg_task_count - 1));
        return 4'($urandom_range(15));
    endfunction

    task automatic send_random();
        int          r, tries;
        logic [4:0]  slot;
        r = $urandom_range(99);
        if (r < 42) begin
            tries = 0;
            slot = 5'($urandom_range(31));
            while (slot_queued[slot] && tries < 16) begin
                slot = 5'($urandom_range(31));
                tries++;
            end
            if (slot_queued[slot])
                send_item(pmqs_pkg::OP_DISPATCH, '0, '0, '0, 4'd0, 0, pmqs_pkg::STS_OK);
            else
                send_item(pmqs_pkg::OP_POST, slot, pick_task(), pick_signal(), '0, 0,
                          pmqs_pkg::STS_OK);
        end else if (r < 64) begin
            send_item(pmqs_pkg::OP_DISPATCH, 5'($urandom_range(31)),
                      4'($urandom_range(15)), 8'($urandom_range(255)),
                      ($urandom_range(99) < 60) ? 4'd0 : 4'($urandom_range(15)),
                      0, pmqs_pkg::STS_OK);
        end else if (r < 86) begin
            send_item(pmqs_pkg::OP_REMOVE, 5'($urandom_range(31)), pick_task(),
                      pick_signal(), 4'($urandom_range(15)), 0, pmqs_pkg::STS_OK);
        end else if (r < 95) begin
            send_item(pmqs_pkg::OP_LEAVE, 5'($urandom_range(31)), 4'($urandom_range(15)),
                      8'($urandom_range(255)), 4'($urandom_range(15)), 0,
                      pmqs_pkg::STS_OK);
        end else begin
            // Unconstrained item; a post here may requeue a slot already queued.
            send_item(pmqs_pkg::op_t'($urandom_range(3)), 5'($urandom_range(31)),
                      4'($urandom_range(15)), 8'($urandom_range(255)),
                      4'($urandom_range(15)), 0, pmqs_pkg::STS_OK);
        end
    endtask

    stim_row_t directed_rows[] = '{
        '{ROW_TYPED, pmqs_pkg::OP_POST, 5'd0, 4'd0, 8'd0, 4'd0,
          pmqs_pkg::STS_BAD_TASK, 48'd0},
        '{ROW_TYPED, pmqs_pkg::OP_REMOVE, 5'd31, 4'd15, 8'd255, 4'd15,
          pmqs_pkg::STS_BAD_TASK, 48'd0},
        '{ROW_TYPED, pmqs_pkg::OP_DISPATCH, 5'd0, 4'd0, 8'd0, 4'd0,
          pmqs_pkg::STS_EMPTY, 48'd0},
        '{ROW_TYPED, pmqs_pkg::OP_LEAVE, 5'd0, 4'd0, 8'd0, 4'd0, pmqs_pkg::STS_OK, 48'd0},
        '{ROW_CFG_COUNT, pmqs_pkg::OP_LEAVE, 5'd0, 4'd0, 8'd0, 4'd0,
          pmqs_pkg::STS_OK, 48'd16},
        '{ROW_CFG_TABLE, pmqs_pkg::OP_LEAVE, 5'd0, 4'd0, 8'd0, 4'd0,
          pmqs_pkg::STS_OK, 48'o7654321076543210},
        '{ROW_SEND, pmqs_pkg::OP_POST, 5'd31, 4'd15, 8'd255, 4'd0, pmqs_pkg::STS_OK, 48'd0},
        '{ROW_SEND, pmqs_pkg::OP_POST, 5'd0, 4'd7, 8'd0, 4'd15, pmqs_pkg::STS_OK, 48'd0},
        '{ROW_SEND, pmqs_pkg::OP_POST, 5'd1, 4'd0, 8'hAA, 4'd0, pmqs_pkg::STS_OK, 48'd0},
        '{ROW_SEND, pmqs_pkg::OP_POST, 5'd2, 4'd0, 8'hAA, 4'd0, pmqs_pkg::STS_OK, 48'd0},
        '{ROW_SEND, pmqs_pkg::OP_POST, 5'd3, 4'd8, 8'h55, 4'd0, pmqs_pkg::STS_OK, 48'd0},
        '{ROW_TYPED, pmqs_pkg::OP_DISPATCH, 5'd0, 4'd0, 8'd0, 4'd8,
          pmqs_pkg::STS_EMPTY, 48'd0},
        '{ROW_TYPED, pmqs_pkg::OP_DISPATCH, 5'd0, 4'd0, 8'd0, 4'd15,
          pmqs_pkg::STS_EMPTY, 48'd0},
        '{ROW_SEND, pmqs_pkg::OP_DISPATCH, 5'd0, 4'd0, 8'd0, 4'd0, pmqs_pkg::STS_OK, 48'd0},
        '{ROW_SEND, pmqs_pkg::OP_DISPATCH, 5'd0, 4'd0, 8'd0, 4'd7, pmqs_pkg::STS_OK, 48'd0},
        '{ROW_SEND, pmqs_pkg::OP_REMOVE, 5'd0, 4'd0, 8'hAA, 4'd0, pmqs_pkg::STS_OK, 48'd0},
        '{ROW_SEND, pmqs_pkg::OP_REMOVE, 5'd0, 4'd8, 8'h00, 4'd0, pmqs_pkg::STS_OK, 48'd0},
        '{ROW_SEND, pmqs_pkg::OP_LEAVE, 5'd0, 4'd0, 8'd0, 4'd0, pmqs_pkg::STS_OK, 48'd0},
        // Requeueing the only queued slot links it to itself, so the walk runs until the MSG_SLOTS step bound stops it.
        '{ROW_SEND, pmqs_pkg::OP_POST, 5'd3, 4'd8, 8'h55, 4'd0, pmqs_pkg::STS_OK, 48'd0},
        '{ROW_SEND, pmqs_pkg::OP_DISPATCH, 5'd0, 4'd0, 8'd0, 4'd0, pmqs_pkg::STS_OK, 48'd0},
        '{ROW_SEND, pmqs_pkg::OP_REMOVE, 5'd0, 4'd8, 8'h55, 4'd0, pmqs_pkg::STS_OK, 48'd0},
        '{ROW_SEND, pmqs_pkg::OP_POST, 5'd16, 4'd9, 8'h0F, 4'd0, pmqs_pkg::STS_OK, 48'd0},
        '{ROW_SEND, pmqs_pkg::OP_DISPATCH, 5'd0, 4'd0, 8'd0, 4'd1, pmqs_pkg::STS_OK, 48'd0},
        '{ROW_SEND, pmqs_pkg::OP_DISPATCH, 5'd0, 4'd0, 8'd0, 4'd0, pmqs_pkg::STS_OK, 48'd0}
    };

    initial begin
        int          phase_idle [4] = '{0, 54, 0, 36};
        int          phase_stall [4] = '{0, 0, 54, 36};
        logic [4:0]  phase_count [4] = '{5'd16, 5'd1, 5'd5, 5'd16};
        logic [47:0] phase_table [4];
        phase_table[0] = {$urandom(), $urandom()};
        phase_table[1] = '0;
        phase_table[2] = '1;
        phase_table[3] = {$urandom(), $urandom()};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_CFG_COUNT: begin
                    wait_idle();
                    write_reg(pmqs_pkg::CFG_TASK_COUNT, directed_rows[i].data);
                end
                ROW_CFG_TABLE: begin
                    wait_idle();
                    write_reg(pmqs_pkg::CFG_LEVEL_TABLE, directed_rows[i].data);
                end
                default: send_item(directed_rows[i].op, directed_rows[i].slot,
                                   directed_rows[i].tid, directed_rows[i].sig,
                                   directed_rows[i].thr, directed_rows[i].kind == ROW_TYPED,
                                   directed_rows[i].sts);
            endcase
        end

        for (int p = 0; p < 4; p++) begin
            wait_idle();
            send_idle_pct = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            write_reg(pmqs_pkg::CFG_TASK_COUNT, {43'd0, phase_count[p]});
            @(posedge aclk);
            write_reg(pmqs_pkg::CFG_LEVEL_TABLE, phase_table[p]);
            repeat (52) send_random();
        end

        wait_idle();
        repeat (40) @(posedge aclk);
        $display("Ran %0d items giving %0d results over four handshake mixes.",
                 items_taken, results_seen);
        $display("Dispatched %0d messages and freed %0d slots by remove.",
                 msgs_dispatched, slots_freed);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
